// ----- rtl/rmit_pkg.sv -----
// Shared types and constants for the range-maximum index tree engine.
// Used by range_max_index_tree_core and its bench; no dependencies.
`timescale 1ns / 1ps

package rmit_pkg;

	localparam int MAX_POSITIONS = 1024;
	localparam int VALUE_WIDTH   = 16;
	localparam int POS_W         = 11;
	localparam int OP_W          = 2;
	localparam int ADDR_W        = $clog2(MAX_POSITIONS);
	localparam int TREE_DEPTH    = 2 * MAX_POSITIONS;
	localparam int NODE_W        = $clog2(TREE_DEPTH);
	localparam int LEVELS        = ADDR_W + 1;
	localparam int LVL_W         = $clog2(LEVELS);
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VISIT,
		ST_TREE_WAIT,
		ST_ELEM_WAIT,
		ST_MERGE,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/rmit_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Standalone; holds the element values and the tree node indices.
`timescale 1ns / 1ps

module rmit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/range_max_index_tree_core.sv -----
// Range-maximum engine: element store, tree builder and query walker.
// Depends on rmit_pkg and rmit_ram.
`timescale 1ns / 1ps

// Usage
//  s_* channel: one item per transaction. s_tuser is the op code (write, build,
//  query); s_tdata carries position, value, left and right. Op code 3 is dropped.
//  m_* channel: one transaction per query with the index of the range maximum
//  (larger index on ties) and an error flag; writes and builds answer nothing.
//  cfg_* channel: writes the count register (reset 1024); write it only idle.
//  Work: a build walks every tree node depth first (one element read per leaf,
//  one tree write per node). A query walks at most about 4*log2(count) nodes;
//  each node it stops at takes a tree read, an element read and a merge, and
//  an invalid range goes straight to the answer state with no walk. One item
//  is worked at a time; the single port of each RAM and the depth-first walk
//  set how long each item takes.
//  A finished result waits in the output register while m_tready is low; the
//  block keeps taking writes and builds, and a later query holds in its final
//  state until the register frees.
//  Reset clears control state and the built size, so queries report an error
//  until the first build. Both RAMs come up undefined; no clearing pass.
module range_max_index_tree_core
	import rmit_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [10:0] position, [26:11] value, [37:27] left, [48:38] right, [55:49] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] op
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [10:0] max_index, [15:11] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [0] range_error
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [POS_W-1:0]      cfg_data
);

	state_t state_q, state_d;

	logic [POS_W-1:0]       count_q;
	logic [POS_W-1:0]       built_q;
	logic                   build_q;
	logic [POS_W-1:0]       ql_q, qr_q;
	logic [NODE_W-1:0]      node_q;
	logic [LVL_W-1:0]       lvl_q;
	logic                   from_right_q;
	logic [POS_W-1:0]       leaf_idx_q;
	logic [POS_W-1:0]       ret_idx_q;
	logic [VALUE_WIDTH-1:0] ret_val_q;
	logic [POS_W-1:0]       res_idx_q;
	logic                   res_err_q;
	logic                   m_tvalid_q;
	logic [POS_W-1:0]       m_idx_q;
	logic                   m_err_q;

	// depth-first walk frames, one per tree level
	logic [POS_W-1:0]       lo_q      [LEVELS];
	logic [POS_W-1:0]       hi_q      [LEVELS];
	logic                   has_q     [LEVELS];
	logic [POS_W-1:0]       acc_idx_q [LEVELS];
	logic [VALUE_WIDTH-1:0] acc_val_q [LEVELS];

	logic                   elem_we, tree_we;
	logic [ADDR_W-1:0]      elem_addr;
	logic [NODE_W-1:0]      tree_addr;
	logic [VALUE_WIDTH-1:0] elem_wdata, elem_rdata;
	logic [POS_W-1:0]       tree_wdata, tree_rdata;

	logic                   in_accept;
	op_t                    in_op;
	logic [POS_W-1:0]       in_position, in_left, in_right;
	logic [VALUE_WIDTH-1:0] in_value;
	logic                   pos_ok, q_err;
	logic [POS_W-1:0]       build_n;
	logic                   out_free;

	logic [POS_W-1:0]       cur_lo, cur_hi, mid;
	logic [POS_W:0]         lo_hi_sum;
	logic                   is_leaf, covered, terminal, go_left, need_right, finish;
	logic                   take_acc;
	logic [POS_W-1:0]       merged_idx;
	logic [VALUE_WIDTH-1:0] merged_val;
	logic [LVL_W-1:0]       lvl_up, lvl_dn;

	assign in_op       = op_t'(s_tuser);
	assign in_position = s_tdata[10:0];
	assign in_value    = s_tdata[26:11];
	assign in_left     = s_tdata[37:27];
	assign in_right    = s_tdata[48:38];
	assign in_accept   = s_tvalid && s_tready;

	assign pos_ok  = (in_position >= POS_W'(1)) && (in_position <= POS_W'(MAX_POSITIONS));
	assign q_err   = (in_left < POS_W'(1)) || (in_left > in_right) ||
		(in_right > count_q) || (in_right > built_q);
	assign build_n = (count_q > POS_W'(MAX_POSITIONS)) ? POS_W'(MAX_POSITIONS) : count_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign cur_lo     = lo_q[lvl_q];
	assign cur_hi     = hi_q[lvl_q];
	assign lo_hi_sum  = {1'b0, cur_lo} + {1'b0, cur_hi};
	assign mid        = lo_hi_sum[POS_W:1];
	assign is_leaf    = (cur_lo == cur_hi);
	assign covered    = (cur_lo >= ql_q) && (cur_hi <= qr_q);
	assign terminal   = build_q ? is_leaf : (is_leaf || covered);
	assign go_left    = build_q || (ql_q <= mid);
	assign need_right = build_q || (qr_q > mid);
	assign finish     = from_right_q || !need_right;
	assign lvl_up     = lvl_q + LVL_W'(1);
	assign lvl_dn     = lvl_q - LVL_W'(1);

	// left result wins only when strictly larger
	assign take_acc   = has_q[lvl_q] && (acc_val_q[lvl_q] > ret_val_q);
	assign merged_idx = take_acc ? acc_idx_q[lvl_q] : ret_idx_q;
	assign merged_val = take_acc ? acc_val_q[lvl_q] : ret_val_q;

	rmit_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (MAX_POSITIONS)
	) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.addr  (elem_addr),
		.wdata (elem_wdata),
		.rdata (elem_rdata)
	);

	rmit_ram #(
		.WIDTH (POS_W),
		.DEPTH (TREE_DEPTH)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.addr  (tree_addr),
		.wdata (tree_wdata),
		.rdata (tree_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (in_op)
						OP_BUILD: state_d = (build_n != '0) ? ST_VISIT : ST_IDLE;
						OP_QUERY: state_d = q_err ? ST_DONE : ST_VISIT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_VISIT: begin
				if (terminal) begin
					state_d = build_q ? ST_ELEM_WAIT : ST_TREE_WAIT;
				end
			end
			ST_TREE_WAIT: state_d = ST_ELEM_WAIT;
			ST_ELEM_WAIT: begin
				if (lvl_q == '0) begin
					state_d = build_q ? ST_IDLE : ST_DONE;
				end else begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (!finish) begin
					state_d = ST_VISIT;
				end else if (lvl_q == '0) begin
					state_d = build_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cfg_ready  = 1'b1;
		elem_we    = 1'b0;
		elem_addr  = ADDR_W'(in_position - POS_W'(1));
		elem_wdata = in_value[VALUE_WIDTH-1:0];
		tree_we    = 1'b0;
		tree_addr  = node_q;
		tree_wdata = merged_idx;
		case (state_q)
			ST_IDLE: begin
				elem_we = in_accept && (in_op == OP_WRITE) && pos_ok;
			end
			ST_VISIT: begin
				elem_addr  = ADDR_W'(cur_lo - POS_W'(1));
				tree_wdata = cur_lo;
				tree_we    = terminal && build_q;
			end
			ST_TREE_WAIT: begin
				elem_addr = ADDR_W'(tree_rdata - POS_W'(1));
			end
			ST_MERGE: begin
				tree_we = finish && build_q;
			end
			default: begin
				elem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= POS_W'(1024);
			built_q      <= '0;
			build_q      <= 1'b0;
			node_q       <= '0;
			lvl_q        <= '0;
			from_right_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					node_q <= NODE_W'(1);
					lvl_q  <= '0;
					if (in_accept && in_op == OP_BUILD) begin
						build_q <= 1'b1;
						built_q <= build_n;
					end else if (in_accept && in_op == OP_QUERY) begin
						build_q <= 1'b0;
					end
				end
				ST_VISIT: begin
					if (!terminal) begin
						lvl_q  <= lvl_up;
						node_q <= {node_q[NODE_W-2:0], !go_left};
					end
				end
				ST_ELEM_WAIT: begin
					if (lvl_q != '0) begin
						node_q       <= node_q >> 1;
						lvl_q        <= lvl_dn;
						from_right_q <= node_q[0];
					end
				end
				ST_MERGE: begin
					if (!finish) begin
						lvl_q  <= lvl_up;
						node_q <= {node_q[NODE_W-2:0], 1'b1};
					end else if (lvl_q != '0) begin
						node_q       <= node_q >> 1;
						lvl_q        <= lvl_dn;
						from_right_q <= node_q[0];
					end
				end
				default: begin
					build_q <= build_q;
				end
			endcase
		end
	end

	// walk payload: frames, leaf and return values, query bounds, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lo_q[0]  <= POS_W'(1);
				has_q[0] <= 1'b0;
				ql_q     <= in_left;
				qr_q     <= in_right;
				hi_q[0]  <= (in_op == OP_BUILD) ? build_n : built_q;
				res_idx_q <= '0;
				res_err_q <= 1'b1;
			end
			ST_VISIT: begin
				leaf_idx_q <= cur_lo;
				if (!terminal) begin
					has_q[lvl_up] <= 1'b0;
					if (go_left) begin
						lo_q[lvl_up] <= cur_lo;
						hi_q[lvl_up] <= mid;
					end else begin
						lo_q[lvl_up] <= mid + POS_W'(1);
						hi_q[lvl_up] <= cur_hi;
					end
				end
			end
			ST_TREE_WAIT: begin
				leaf_idx_q <= tree_rdata;
			end
			ST_ELEM_WAIT: begin
				ret_idx_q <= leaf_idx_q;
				ret_val_q <= elem_rdata;
				res_idx_q <= leaf_idx_q;
				res_err_q <= 1'b0;
			end
			ST_MERGE: begin
				ret_idx_q <= merged_idx;
				ret_val_q <= merged_val;
				res_idx_q <= merged_idx;
				res_err_q <= 1'b0;
				if (!finish) begin
					// park the left result, then descend right
					acc_idx_q[lvl_q] <= merged_idx;
					acc_val_q[lvl_q] <= merged_val;
					has_q[lvl_q]     <= 1'b1;
					has_q[lvl_up]    <= 1'b0;
					lo_q[lvl_up]     <= mid + POS_W'(1);
					hi_q[lvl_up]     <= cur_hi;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_idx_q <= res_idx_q;
					m_err_q <= res_err_q;
				end
			end
			default: begin
				ret_idx_q <= ret_idx_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - POS_W){1'b0}}, m_idx_q};
	assign m_tuser  = m_err_q;

`ifndef SYNTHESIS
	a_err_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error result carries a nonzero index");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !res_err_q) |-> (res_idx_q >= ql_q && res_idx_q <= qr_q))
		else $error("query result outside the queried range");

	a_parked_from_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && has_q[lvl_q]) |-> from_right_q)
		else $error("parked left result merged with another left result");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VISIT) |-> (lvl_q < LVL_W'(LEVELS)))
		else $error("walk level beyond tree height");
`endif

endmodule

// ----- test/range_max_index_tree_core_test.sv -----
// Self-checking bench for range_max_index_tree_core: writes, builds and range-max
// queries over the stream ports, checked against an in-bench segment tree mirror.
// Depends on rmit_pkg and the RTL of range_max_index_tree_core.
`timescale 1ns / 1ps

module range_max_index_tree_core_test;
	import rmit_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned TREE_SLOTS = 4 * MAX_POSITIONS;
	localparam int unsigned FIELD_BITS = 3 * POS_W + VALUE_WIDTH;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 80;
	localparam int unsigned PRESSURE_PHASE = 2;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN_LIMIT = 20000;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned POS_TOP = (1 << POS_W) - 1;

	typedef enum {ROW_ITEM, ROW_COUNT} row_kind_e;

	typedef struct {
		logic [OP_W-1:0]        op;
		logic [POS_W-1:0]       position;
		logic [VALUE_WIDTH-1:0] value;
		logic [POS_W-1:0]       left;
		logic [POS_W-1:0]       right;
	} item_t;

	typedef struct {
		logic [POS_W-1:0] max_index;
		logic             range_error;
	} answer_t;

	typedef struct {
		row_kind_e kind;
		item_t     item;
		bit        typed;
		answer_t   answer;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [POS_W-1:0]      cfg_data;

	range_max_index_tree_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// mirror of the block state
	logic [VALUE_WIDTH-1:0] elem_mirror [0:MAX_POSITIONS];
	bit                     written [0:MAX_POSITIONS];
	int unsigned            tree_mirror [0:TREE_SLOTS-1];
	int unsigned            built_n = 0;
	logic [POS_W-1:0]       count_reg = MAX_POSITIONS;

	answer_t     pending_answers[$];
	script_row_t script[$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned builds_sent = 0;
	int unsigned answers_seen = 0;
	int unsigned error_answers = 0;
	int unsigned settings_done = 0;
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [VALUE_WIDTH-1:0] value_at(int unsigned pos);
		if (pos == 0 || pos > MAX_POSITIONS)
			return '0;
		return elem_mirror[pos];
	endfunction

	function automatic int unsigned node_at(int unsigned node);
		return node < TREE_SLOTS ? tree_mirror[node] : 0;
	endfunction

	// larger value wins, the right-hand position on a tie
	function automatic int unsigned stronger(int unsigned a, int unsigned b);
		return value_at(a) > value_at(b) ? a : b;
	endfunction

	function automatic void grow(int unsigned node, int unsigned lo, int unsigned hi);
		int unsigned mid;
		if (node >= TREE_SLOTS)
			return;
		if (lo == hi) begin
			tree_mirror[node] = lo;
			return;
		end
		mid = (lo + hi) / 2;
		grow(2 * node, lo, mid);
		grow(2 * node + 1, mid + 1, hi);
		tree_mirror[node] = stronger(node_at(2 * node), node_at(2 * node + 1));
	endfunction

	function automatic int unsigned walk(int unsigned node, int unsigned lo, int unsigned hi,
			int unsigned ql, int unsigned qr);
		int unsigned mid;
		if ((lo >= ql && hi <= qr) || lo == hi || node >= TREE_SLOTS)
			return node_at(node);
		mid = (lo + hi) / 2;
		if (qr <= mid)
			return walk(2 * node, lo, mid, ql, qr);
		if (ql > mid)
			return walk(2 * node + 1, mid + 1, hi, ql, qr);
		return stronger(walk(2 * node, lo, mid, ql, mid),
			walk(2 * node + 1, mid + 1, hi, mid + 1, qr));
	endfunction

	// apply one accepted transaction to the mirror; returns 1 when it answers
	function automatic bit range_max_predict(input item_t it, output answer_t ans);
		int unsigned n;
		ans.max_index = '0;
		ans.range_error = 1'b0;
		case (it.op)
			OP_WRITE: begin
				if (it.position >= 1 && it.position <= MAX_POSITIONS) begin
					elem_mirror[it.position] = it.value;
					written[it.position] = 1'b1;
				end
			end
			OP_BUILD: begin
				n = count_reg > MAX_POSITIONS ? MAX_POSITIONS : count_reg;
				built_n = n;
				if (n >= 1)
					grow(1, 1, n);
			end
			OP_QUERY: begin
				if (it.left < 1 || it.left > it.right || it.right > count_reg
						|| it.right > built_n)
					ans.range_error = 1'b1;
				else
					ans.max_index = walk(1, 1, built_n, it.left, it.right);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		// small values make ties common
		if (roll < 3)
			return $urandom_range(0, 3);
		if (roll == 3)
			return $urandom_range(0, 1) ? '1 : '0;
		return $urandom;
	endfunction

	function automatic item_t random_item(logic [OP_W-1:0] op);
		item_t it;
		it.op = op;
		it.position = $urandom;
		it.value = $urandom;
		it.left = $urandom;
		it.right = $urandom;
		return it;
	endfunction

	function automatic item_t make_query(bit valid_only);
		item_t       it;
		int unsigned lim, l, r;
		it = random_item(OP_QUERY);
		lim = count_reg < built_n ? count_reg : built_n;
		if (lim != 0 && (valid_only || $urandom_range(0, 4) != 0)) begin
			l = $urandom_range(1, lim);
			r = $urandom_range(l, lim);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					l = 0;
					r = $urandom_range(0, POS_TOP);
				end
				1: begin
					l = $urandom_range(2, POS_TOP);
					r = $urandom_range(1, l - 1);
				end
				2: begin
					r = $urandom_range(lim + 1, POS_TOP);
					l = $urandom_range(1, r);
				end
				default: begin
					l = $urandom_range(0, POS_TOP);
					r = $urandom_range(0, POS_TOP);
				end
			endcase
		end
		it.left = l;
		it.right = r;
		return it;
	endfunction

	task automatic note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
	endtask

	// present one item, hold it until the transaction, then update the mirror
	task automatic send_item(input item_t it, input bit typed, input answer_t typed_ans);
		int unsigned gap;
		answer_t     ans;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - FIELD_BITS){1'b0}}, it.right, it.left, it.value, it.position};
		s_tuser <= it.op;
		do @(posedge clk); while (!s_tready);
		if (it.op != OP_UNUSED)
			items_sent++;
		if (it.op == OP_BUILD)
			builds_sent++;
		if (range_max_predict(it, ans))
			pending_answers.push_back(typed ? typed_ans : ans);
	endtask

	// every position a build reads must hold a written value first
	task automatic build_tree();
		item_t       it;
		answer_t     none;
		int unsigned n, p;
		none.max_index = '0;
		none.range_error = 1'b0;
		n = count_reg > MAX_POSITIONS ? MAX_POSITIONS : count_reg;
		for (p = 1; p <= n; p++) begin
			if (!written[p]) begin
				it = random_item(OP_WRITE);
				it.position = p;
				it.value = pick_value();
				send_item(it, 1'b0, none);
			end
		end
		send_item(random_item(OP_BUILD), 1'b0, none);
	endtask

	// drop valid, drain answers, then let a build in flight finish
	task automatic settle();
		int unsigned w;
		s_tvalid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && pending_answers.size() != 0; w++)
			@(posedge clk);
		repeat (6 * built_n + 200) @(posedge clk);
	endtask

	task automatic write_count(input logic [POS_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_reg = v;
		settings_done++;
	endtask

	task automatic put(row_kind_e kind, logic [OP_W-1:0] op, int pos, int val, int lo, int hi,
			bit typed, int idx, bit err);
		script_row_t row;
		row.kind = kind;
		row.item.op = op;
		row.item.position = pos;
		row.item.value = val;
		row.item.left = lo;
		row.item.right = hi;
		row.typed = typed;
		row.answer.max_index = idx;
		row.answer.range_error = err;
		script.push_back(row);
	endtask

	always @(posedge clk) begin : answer_check
		answer_t got;
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (m_tuser)
				error_answers++;
			if (pending_answers.size() == 0) begin
				note_mismatch("answer with none pending, max_index", 0, m_tdata);
			end else begin
				got = pending_answers.pop_front();
				if (m_tdata != {{(OUT_DATA_W - POS_W){1'b0}}, got.max_index})
					note_mismatch("max_index", got.max_index, m_tdata);
				if (m_tuser != got.range_error)
					note_mismatch("range_error", got.range_error, m_tuser);
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = gap_len();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		item_t       it;
		answer_t     none;
		int unsigned k, n, roll, wlim, next_count;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		none.max_index = '0;
		none.range_error = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at reset: nothing built yet, so every query flags a bad range
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 1, 1, 0, 1);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 1024, 1, 0, 1);
		put(ROW_ITEM, OP_QUERY, 2047, 'hFFFF, 2047, 2047, 1, 0, 1);
		put(ROW_ITEM, OP_UNUSED, 2047, 'hFFFF, 2047, 2047, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 0, 'hFFFF, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 2047, 'hFFFF, 0, 0, 0, 0, 0);
		put(ROW_COUNT, OP_WRITE, 4, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 1, 'hFFFF, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 2, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 3, 'hFFFF, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_WRITE, 4, 7, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 4, 1, 3, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 2, 1, 1, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 0, 3, 1, 0, 1);
		put(ROW_ITEM, OP_QUERY, 0, 0, 3, 2, 1, 0, 1);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 5, 1, 0, 1);
		// stale tree: write after the build, no rebuild
		put(ROW_ITEM, OP_WRITE, 3, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 4, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 2, 4, 0, 0, 0);
		put(ROW_ITEM, OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 4, 0, 0, 0);
		put(ROW_COUNT, OP_WRITE, 0, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 1, 1, 0, 1);
		put(ROW_ITEM, OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
		put(ROW_COUNT, OP_WRITE, 4, 0, 0, 0, 0, 0, 0);
		put(ROW_ITEM, OP_QUERY, 0, 0, 1, 1, 1, 0, 1);

		foreach (script[i]) begin
			if (script[i].kind == ROW_COUNT) begin
				settle();
				write_count(script[i].item.position);
			end else begin
				send_item(script[i].item, script[i].typed, script[i].answer);
			end
		end

		for (k = 0; k < PHASES; k++) begin
			idle_on = (k % 4 != 1);
			case (k)
				0: next_count = 2047;
				1: next_count = 1;
				2: next_count = 64;
				3: next_count = 0;
				4: next_count = MAX_POSITIONS;
				5: next_count = 2;
				default: next_count = $urandom_range(3, 48);
			endcase
			settle();
			write_count(next_count);
			build_tree();
			if (k == PRESSURE_PHASE) begin
				// hold the result side while queries keep coming
				hold_request = 1'b1;
				repeat (24) send_item(make_query(1'b1), 1'b0, none);
			end
			wlim = count_reg > MAX_POSITIONS ? MAX_POSITIONS : (count_reg == 0 ? 1 : count_reg);
			n = 0;
			while (n < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 48) begin
					send_item(make_query(1'b0), 1'b0, none);
				end else if (roll < 92) begin
					it = random_item(OP_WRITE);
					it.value = pick_value();
					case ($urandom_range(0, 19))
						0: it.position = 0;
						1: it.position = $urandom_range(MAX_POSITIONS + 1, POS_TOP);
						2: it.position = $urandom_range(1, MAX_POSITIONS);
						default: it.position = $urandom_range(1, wlim);
					endcase
					send_item(it, 1'b0, none);
				end else if (roll < 96) begin
					build_tree();
				end else begin
					send_item(random_item(OP_UNUSED), 1'b0, none);
					continue;
				end
				n++;
			end
			// close on a query so the block is known idle once it answers
			send_item(make_query(1'b0), 1'b0, none);
		end
		settle();

		if (pending_answers.size() != 0) begin
			$display("%0d expected answers never arrived", pending_answers.size());
			mismatches += pending_answers.size();
		end
		$display("Covered %0d items over %0d count settings: %0d builds, %0d answers, %0d flagged.",
			items_sent, settings_done, builds_sent, answers_seen, error_answers);
		$display("Result side held off %0d cycles once while queries kept arriving.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rmit_pkg.sv
rtl/rmit_ram.sv
rtl/range_max_index_tree_core.sv
test/range_max_index_tree_core_test.sv
